// ===== rtl/pseudo_float_encoder_core_defines.svh =====
// Assertion macros for the pseudo-float encoder core.
// Needs nothing else; included by the top level, which holds the assertions.
`ifndef PSEUDO_FLOAT_ENCODER_CORE_DEFINES_SVH
`define PSEUDO_FLOAT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error(msg);

`endif

// ===== rtl/pfe_pkg.sv =====
// Shared types and constants of the pseudo-float encoder core.
// Depends on nothing; used by pfe_div and pseudo_float_encoder_core.
`default_nettype none

package pfe_pkg;

	localparam int MANT_W = 24;
	localparam int VAL_W  = 64;
	localparam int DIV_W  = 32;
	localparam int EXP_W  = 8;

	localparam logic [1:0] FUNC_RAW   = 2'd0;
	localparam logic [1:0] FUNC_RECIP = 2'd1;
	localparam logic [1:0] FUNC_DIV   = 2'd2;

	// Starting exponents of the division modes, two's complement.
	localparam logic [EXP_W-1:0] RECIP_EXP = 8'hC0;
	localparam logic [EXP_W-1:0] DIV_EXP   = 8'hE0;

	typedef struct packed {
		logic [1:0]              func;
		logic [VAL_W-1:0]        value;
		logic signed [EXP_W-1:0] exponent_in;
		logic [DIV_W-1:0]        divisor;
	} req_t;

	typedef struct packed {
		logic [31:0] encoded;
		logic        div_by_zero;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_NORM,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Depends on pfe_pkg for the request and response structs.
`default_nettype none

module pfe_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(pfe_pkg::VAL_W);

	logic                      run_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [pfe_pkg::VAL_W-1:0] qd_q;
	logic [pfe_pkg::DIV_W-1:0] rem_q;
	logic [pfe_pkg::DIV_W-1:0] dvs_q;

	logic [pfe_pkg::DIV_W:0]   rem_sh;
	logic [pfe_pkg::DIV_W:0]   rem_sub;
	logic                      ge;
	logic                      last;

	assign rem_sh  = {rem_q, qd_q[pfe_pkg::VAL_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign last    = cnt_q == CNT_W'(pfe_pkg::VAL_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Dividend bits leave at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			qd_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			qd_q  <= {qd_q[pfe_pkg::VAL_W-2:0], ge};
			rem_q <= ge ? rem_sub[pfe_pkg::DIV_W-1:0] : rem_sh[pfe_pkg::DIV_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = qd_q;

endmodule

`default_nettype wire

// ===== rtl/pseudo_float_encoder_core.sv =====
// Pseudo-float encoder core: sequencer, normalizer and rounding around pfe_div.
// Depends on pfe_pkg, pfe_div and pseudo_float_encoder_core_defines.svh.
//
// Usage: drive req and raise start while busy is low; the request transfers
// at that clock edge and busy rises. One result follows: done is high for
// exactly one cycle with res valid in that cycle, and the receiver must take
// it then. busy falls the cycle after done, so a new request may transfer
// in the cycle after the result.
// In the raw mode the request goes through normalization, where k right shifts
// bring the value below 2^24 (k from 0 to 40) and one shift is done per cycle,
// then through rounding and the done state. The reciprocal and divide modes
// first run the restoring divider, one quotient bit per cycle, then normalize.
// A zero reciprocal operand, a zero divisor or the unused selector raises done
// in the cycle right after the request edge.
// Reset clears the sequencer and the divider control; no request is in flight.
// There is no backpressure on the result side.
`default_nettype none
`include "pseudo_float_encoder_core_defines.svh"

module pseudo_float_encoder_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire pfe_pkg::req_t req,
	output logic               done,
	output pfe_pkg::res_t      res
);

	localparam int MW = pfe_pkg::MANT_W;
	localparam int VW = pfe_pkg::VAL_W;
	localparam int EW = pfe_pkg::EXP_W;

	pfe_pkg::state_t   state_q, state_d;
	pfe_pkg::div_req_t div_req;
	pfe_pkg::div_rsp_t div_rsp;

	logic [VW-1:0] mag_q;
	logic [EW-1:0] exp_q;
	logic          last_q;
	pfe_pkg::res_t res_q;

	logic          accept;
	logic          need_div;
	logic          big;
	logic [MW:0]   rnd_sum;
	logic [31:0]   low32;

	assign accept = start && (state_q == pfe_pkg::ST_IDLE);
	assign low32  = req.value[31:0];
	assign big    = mag_q[VW-1:MW] != '0;
	assign rnd_sum = {1'b0, mag_q[MW-1:0]} + (MW+1)'(last_q);

	always_comb begin
		need_div = 1'b0;
		unique case (req.func)
			pfe_pkg::FUNC_RECIP: need_div = low32 != '0;
			pfe_pkg::FUNC_DIV:   need_div = req.divisor != '0;
			default:             need_div = 1'b0;
		endcase
	end

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfe_pkg::ST_IDLE: begin
				if (start) begin
					if (need_div) begin
						state_d = pfe_pkg::ST_DIV;
					end else if (req.func == pfe_pkg::FUNC_RAW) begin
						state_d = pfe_pkg::ST_NORM;
					end else begin
						state_d = pfe_pkg::ST_DONE;
					end
				end
			end
			pfe_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = pfe_pkg::ST_NORM;
				end
			end
			pfe_pkg::ST_NORM: begin
				if (!big) begin
					state_d = pfe_pkg::ST_ROUND;
				end
			end
			pfe_pkg::ST_ROUND: state_d = pfe_pkg::ST_DONE;
			pfe_pkg::ST_DONE:  state_d = pfe_pkg::ST_IDLE;
			default:           state_d = pfe_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy             = state_q != pfe_pkg::ST_IDLE;
		done             = state_q == pfe_pkg::ST_DONE;
		div_req.start    = accept && need_div;
		div_req.divisor  = (req.func == pfe_pkg::FUNC_RECIP) ? low32 : req.divisor;
		div_req.dividend = (req.func == pfe_pkg::FUNC_RECIP) ? {VW{1'b1}} : {low32, 32'h0};
	end

	assign res = res_q;

	// Datapath: load mag_q, then one shift or rounding add per cycle.
	always_ff @(posedge clk) begin
		unique case (state_q)
			pfe_pkg::ST_IDLE: begin
				last_q            <= 1'b0;
				mag_q             <= req.value;
				res_q.encoded     <= '0;
				res_q.div_by_zero <= (req.func == pfe_pkg::FUNC_DIV) && (req.divisor == '0);
				unique case (req.func)
					pfe_pkg::FUNC_RAW:   exp_q <= req.exponent_in;
					pfe_pkg::FUNC_RECIP: exp_q <= pfe_pkg::RECIP_EXP;
					pfe_pkg::FUNC_DIV:   exp_q <= pfe_pkg::DIV_EXP;
					default:             exp_q <= '0;
				endcase
			end
			pfe_pkg::ST_DIV: begin
				mag_q <= div_rsp.quotient;
			end
			pfe_pkg::ST_NORM: begin
				if (big) begin
					last_q <= mag_q[0];
					mag_q  <= {1'b0, mag_q[VW-1:1]};
					exp_q  <= exp_q + 1'b1;
				end
			end
			pfe_pkg::ST_ROUND: begin
				// Renormalize when rounding carries out of the mantissa.
				if (rnd_sum[MW]) begin
					res_q.encoded <= {exp_q + 1'b1, rnd_sum[MW:1]};
				end else begin
					res_q.encoded <= {exp_q, rnd_sum[MW-1:0]};
				end
				res_q.div_by_zero <= 1'b0;
			end
			pfe_pkg::ST_DONE: begin
				last_q <= last_q;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	`PFE_ASSERT_IMPLY(a_done_busy, clk, arst_n, done, busy, "result strobe outside a request")
	`PFE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy,
		"request transfer not held busy")
	`PFE_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy,
		"result strobe longer than one cycle")
	`PFE_ASSERT_IMPLY(a_dz_zero, clk, arst_n, done && res.div_by_zero, res.encoded == '0,
		"division by zero with nonzero word")

endmodule

`default_nettype wire

// ===== verif/tb_pseudo_float_encoder_core.sv =====
// Testbench for pseudo_float_encoder_core: directed and random requests in all modes,
// each result checked against a predicted 24-bit mantissa / 8-bit exponent encoding.
// Depends on pfe_pkg and the pseudo_float_encoder_core RTL.
`timescale 1ns / 100ps

module tb_pseudo_float_encoder_core;
	import pfe_pkg::*;

	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam logic [63:0] MANT_LIMIT  = 64'd1 << MANT_W;
	localparam int          RANDOM_PER_PHASE = 134;
	localparam int          DRAIN_CYCLES     = 120;
	localparam int          CYCLE_LIMIT      = 500000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	res_t res;

	req_t requests_to_send[$];
	res_t pending_encodings[$];
	int   sender_idle_pct = 22;
	logic took_last = 1'b0;
	int   mismatch_count  = 0;
	int   results_checked = 0;
	int   func_hits[4]    = '{0, 0, 0, 0};
	int   cycle_count     = 0;

	pseudo_float_encoder_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.res   (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shift right to fit the mantissa, then round by the last bit shifted out.
	function automatic logic [31:0] round_to_pseudo_float(logic [63:0] mag_in,
			logic [7:0] exp_in);
		logic [63:0] mag;
		logic [7:0]  ex;
		logic        lost;
		mag  = mag_in;
		ex   = exp_in;
		lost = 1'b0;
		while (mag >= MANT_LIMIT) begin
			lost = mag[0];
			mag  = mag >> 1;
			ex   = ex + 8'd1;
		end
		if (lost) begin
			mag = mag + 64'd1;
			if (mag >= MANT_LIMIT) begin
				mag = mag >> 1;
				ex  = ex + 8'd1;
			end
		end
		return {ex, mag[23:0]};
	endfunction

	function automatic res_t expected_encoding(req_t r);
		logic [31:0] low;
		res_t        o;
		o   = '0;
		low = r.value[31:0];
		case (r.func)
			FUNC_RAW: begin
				o.encoded = round_to_pseudo_float(r.value, r.exponent_in);
			end
			FUNC_RECIP: begin
				if (low != 32'd0)
					o.encoded = round_to_pseudo_float(64'hFFFF_FFFF_FFFF_FFFF / {32'd0, low},
						RECIP_EXP);
			end
			FUNC_DIV: begin
				if (r.divisor == 32'd0)
					o.div_by_zero = 1'b1;
				else
					o.encoded = round_to_pseudo_float({low, 32'd0} / {32'd0, r.divisor},
						DIV_EXP);
			end
			default: ;
		endcase
		return o;
	endfunction

	// Random value of random bit length, so that every shift count shows up.
	function automatic logic [63:0] ranged_random(int bits);
		logic [63:0] full;
		int          w;
		full = {$urandom, $urandom};
		w    = $urandom_range(bits, 1);
		return full >> (64 - w);
	endfunction

	task automatic queue_request(logic [1:0] f, logic [63:0] v, logic [7:0] e,
			logic [31:0] d);
		req_t r;
		r.func        = f;
		r.value       = v;
		r.exponent_in = e;
		r.divisor     = d;
		requests_to_send.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("[%0t] %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
	endtask

	// Driver: hold a request until it transfers, then pull the next one or idle.
	always @(negedge clk) begin : drive_proc
		logic drive_next;
		req_t next_req;
		drive_next = start && !took_last;
		next_req   = req;
		if (arst_n && !drive_next && requests_to_send.size() > 0
				&& $urandom_range(99) >= sender_idle_pct) begin
			next_req   = requests_to_send.pop_front();
			drive_next = 1'b1;
		end
		start <= arst_n ? drive_next : 1'b0;
		req   <= next_req;
	end

	// Monitor: check each result against the oldest expectation, then record transfers.
	always @(posedge clk) begin : monitor_proc
		res_t want;
		took_last <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (pending_encodings.size() == 0) begin
					report_mismatch("result with nothing outstanding", res.encoded, 32'd0);
				end else begin
					want = pending_encodings.pop_front();
					if (res.encoded !== want.encoded)
						report_mismatch("encoded", res.encoded, want.encoded);
					if (res.div_by_zero !== want.div_by_zero)
						report_mismatch("div_by_zero", {31'd0, res.div_by_zero},
							{31'd0, want.div_by_zero});
					results_checked++;
				end
			end
			if (start && !busy) begin
				pending_encodings.push_back(expected_encoding(req));
				func_hits[req.func]++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus_proc
		logic [1:0]  f;
		logic [63:0] v;
		logic [31:0] d;
		int          pick;

		// Boundaries, rounding carry, exponent wrap and every zero case.
		queue_request(FUNC_RAW, 64'd0, 8'h00, 32'd0);
		queue_request(FUNC_RAW, 64'hFF_FFFF, 8'h80, 32'hFFFF_FFFF);
		queue_request(FUNC_RAW, 64'h100_0000, 8'h05, 32'd0);
		queue_request(FUNC_RAW, 64'h1FF_FFFF, 8'h00, 32'd0);
		queue_request(FUNC_RAW, 64'h2FF_FFFF, 8'h7F, 32'd0);
		queue_request(FUNC_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h7F, 32'd0);
		queue_request(FUNC_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 32'd0);
		queue_request(FUNC_RAW, 64'h8000_0000_0000_0000, 8'hFF, 32'd0);
		queue_request(FUNC_RAW, 64'h5555_5555_5555_5555, 8'h55, 32'hAAAA_AAAA);
		queue_request(FUNC_RECIP, 64'd0, 8'h00, 32'd0);
		queue_request(FUNC_RECIP, 64'hFFFF_FFFF_0000_0000, 8'h7F, 32'd0);
		queue_request(FUNC_RECIP, 64'd1, 8'h00, 32'd0);
		queue_request(FUNC_RECIP, 64'hFFFF_FFFF, 8'h80, 32'hFFFF_FFFF);
		queue_request(FUNC_RECIP, 64'd3, 8'h00, 32'd0);
		queue_request(FUNC_DIV, 64'd5, 8'h00, 32'd0);
		queue_request(FUNC_DIV, 64'd0, 8'h00, 32'd0);
		queue_request(FUNC_DIV, 64'd0, 8'h00, 32'd7);
		queue_request(FUNC_DIV, 64'hFFFF_FFFF, 8'h00, 32'd1);
		queue_request(FUNC_DIV, 64'd1, 8'h00, 32'hFFFF_FFFF);
		queue_request(FUNC_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF);
		queue_request(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'd0);
		queue_request(FUNC_UNUSED, 64'd0, 8'h00, 32'hFFFF_FFFF);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 54 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				f = (pick < 35) ? FUNC_RAW : (pick < 65) ? FUNC_RECIP :
					(pick < 96) ? FUNC_DIV : FUNC_UNUSED;
				pick = $urandom_range(7);
				if (pick == 0)
					v = 64'h1FF_FFFF << $urandom_range(39);
				else if (pick == 1)
					v = {$urandom, $urandom};
				else
					v = ranged_random(64);
				d = ($urandom_range(19) == 0) ? 32'd0 : 32'(ranged_random(32));
				queue_request(f, v, 8'($urandom), d);
			end
			while (requests_to_send.size() != 0 || start) @(posedge clk);
		end

		while (pending_encodings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_encodings.size() != 0)
			report_mismatch("results never delivered", 32'(pending_encodings.size()), 32'd0);

		$display("checked %0d results: %0d raw, %0d reciprocal, %0d divide, %0d unused selector",
			results_checked, func_hits[FUNC_RAW], func_hits[FUNC_RECIP], func_hits[FUNC_DIV],
			func_hits[FUNC_UNUSED]);
		$display("sender idle at 22, 54 and 0 percent; %0d mismatches", mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
